// ----- rtl/rbch_pkg.sv -----
// ----------------------------------------------------------------------------
// rbch_pkg
// Shared types, register indexes, codes and a saturation helper for the
// closest-hit box list ray caster.
// ----------------------------------------------------------------------------
package rbch_pkg;

    typedef struct packed {
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic               last_box;
    } t_box;

    typedef struct packed {
        logic               hit;
        logic [30:0]        distance;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [1:0]         normal_code;
    } t_result;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_DIR_X     = 3'd2,
        CFG_DIR_Y     = 3'd3,
        CFG_MAX_PARAM = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] NRM_NEG_X = 2'd0;
    localparam logic [1:0] NRM_POS_X = 2'd1;
    localparam logic [1:0] NRM_NEG_Y = 2'd2;
    localparam logic [1:0] NRM_POS_Y = 2'd3;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic signed [65:0] LIM_HI  = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] LIM_LO  = -66'sh0_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > LIM_HI) begin
            return SAT_MAX;
        end else if (v < LIM_LO) begin
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/rbch_div.sv -----
// ----------------------------------------------------------------------------
// rbch_div
// Restoring divider for the reciprocal 2^32 / den, one quotient bit per cycle,
// truncated toward zero and saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module rbch_div import rbch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic signed [31:0] r_out, n_out;

    logic [31:0] w_mag;
    logic [32:0] w_sh;
    logic        w_ge;
    logic [32:0] w_qm;

    assign w_mag = i_den[31] ? (~i_den + 32'd1) : i_den;
    // numerator has a single one at bit 32
    assign w_sh  = {r_rem, (r_cnt == 6'd32)};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_qm  = {r_quo, w_ge};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_out  = r_out;
        if (i_start) begin
            if (i_den == 32'sd0) begin
                n_out  = SAT_MAX;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_cnt  = 6'd32;
                n_rem  = '0;
                n_quo  = '0;
                n_den  = w_mag;
                n_neg  = i_den[31];
            end
        end else if (r_busy) begin
            n_rem = w_ge ? 32'(w_sh - {1'b0, r_den}) : w_sh[31:0];
            n_quo = w_qm[31:0];
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (!r_neg) begin
                    n_out = (w_qm[32] || w_qm[31]) ? SAT_MAX : $signed(w_qm[31:0]);
                end else begin
                    n_out = (w_qm > 33'h0_8000_0000) ? SAT_MIN
                                                     : $signed(~w_qm[31:0] + 32'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_quot = r_out;

endmodule

// ----- rtl/rbch_sqrt.sv -----
// ----------------------------------------------------------------------------
// rbch_sqrt
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rbch_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_n, n_n;
    logic [63:0] r_r, n_r;
    logic [63:0] r_b, n_b;

    logic [63:0] w_sum;
    logic        w_ge;

    assign w_sum = r_r + r_b;
    assign w_ge  = r_n >= w_sum;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_n    = r_n;
        n_r    = r_r;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_n    = i_val;
            n_r    = '0;
            n_b    = 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (w_ge) begin
                n_n = r_n - w_sum;
                n_r = (r_r >> 1) + r_b;
            end else begin
                n_r = r_r >> 1;
            end
            n_b   = r_b >> 2;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_n <= n_n;
        r_r <= n_r;
        r_b <= n_b;
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

// ----- rtl/ray_box_list_closest_hit.sv -----
// ----------------------------------------------------------------------------
// ray_box_list_closest_hit
// Closest-hit slab test of one 2D ray against a stream of boxes.
// ----------------------------------------------------------------------------
// Boxes are taken one at a time; the input stalls while a box is in work.
// An ordinary box takes four slab products on the one shared 33x33
// multiplier plus the test; when it becomes the new closest hit, two more
// products for the hit point and then the normal pick follow. The first
// box of a query adds two 33-step reciprocal divisions run on the serial
// divider, then two squaring products and a 32-step square root for the
// direction length; a zero direction component skips its division steps.
// A last box adds the distance product; its result word waits in an output
// register, and the next query may start while it waits.
module ray_box_list_closest_hit import rbch_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_box        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DIVX = 10'b00_0000_0010,
        S_DIVY = 10'b00_0000_0100,
        S_SQ   = 10'b00_0000_1000,
        S_SQRT = 10'b00_0001_0000,
        S_SLAB = 10'b00_0010_0000,
        S_TEST = 10'b00_0100_0000,
        S_PNT  = 10'b00_1000_0000,
        S_NORM = 10'b01_0000_0000,
        S_DIST = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    logic signed [31:0] r_ox, r_oy, r_dx, r_dy;
    logic [30:0]        r_maxp;

    logic               r_active;
    logic signed [31:0] r_inv_x, r_inv_y;
    logic [31:0]        r_dir_len;
    logic [30:0]        r_best_param;
    logic               r_best_hit;
    logic signed [31:0] r_best_px, r_best_py;
    logic [1:0]         r_best_nrm;
    t_box               r_box;
    logic signed [31:0] r_t [4];
    logic signed [31:0] r_tmin;
    logic signed [31:0] r_px, r_py;
    logic [63:0]        r_sum;
    logic signed [65:0] r_prod;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_accept;
    logic               w_mul_en;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic signed [65:0] w_shr;
    logic               w_div_start, w_div_done;
    logic signed [31:0] w_div_den, w_div_quot;
    logic               w_sqrt_start, w_sqrt_done;
    logic [31:0]        w_sqrt_root;
    logic [31:0]        w_ax, w_ay;
    logic signed [31:0] w_tmin, w_tmax;
    logic               w_cand;
    logic [1:0]         w_tidx;
    logic               w_slot_free;
    logic signed [35:0] w_offx2, w_offy2, w_ovx2, w_ovy2;
    logic [49:0]        w_dist_full;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_ax = r_dx[31] ? (~r_dx + 32'd1) : r_dx;
    assign w_ay = r_dy[31] ? (~r_dy + 32'd1) : r_dy;
    assign w_tidx = 2'(r_cnt - 3'd1);

    // shared multiplier operand select
    always_comb begin
        w_mul_en = 1'b0;
        w_ma     = '0;
        w_mb     = '0;
        case (r_state)
            S_SQ: begin
                w_mul_en = (r_cnt != 3'd2);
                w_ma = (r_cnt == 3'd0) ? $signed({1'b0, w_ax}) : $signed({1'b0, w_ay});
                w_mb = w_ma;
            end
            S_SLAB: begin
                w_mul_en = (r_cnt != 3'd4);
                case (r_cnt)
                    3'd0: begin
                        w_ma = $signed({r_box.box_min_x[31], r_box.box_min_x})
                             - $signed({r_ox[31], r_ox});
                        w_mb = $signed({r_inv_x[31], r_inv_x});
                    end
                    3'd1: begin
                        w_ma = $signed({r_box.box_max_x[31], r_box.box_max_x})
                             - $signed({r_ox[31], r_ox});
                        w_mb = $signed({r_inv_x[31], r_inv_x});
                    end
                    3'd2: begin
                        w_ma = $signed({r_box.box_min_y[31], r_box.box_min_y})
                             - $signed({r_oy[31], r_oy});
                        w_mb = $signed({r_inv_y[31], r_inv_y});
                    end
                    default: begin
                        w_ma = $signed({r_box.box_max_y[31], r_box.box_max_y})
                             - $signed({r_oy[31], r_oy});
                        w_mb = $signed({r_inv_y[31], r_inv_y});
                    end
                endcase
            end
            S_PNT: begin
                w_mul_en = (r_cnt != 3'd2);
                w_ma = (r_cnt == 3'd0) ? $signed({r_dx[31], r_dx}) : $signed({r_dy[31], r_dy});
                w_mb = $signed({r_tmin[31], r_tmin});
            end
            S_DIST: begin
                w_mul_en = (r_cnt == 3'd0);
                w_ma = $signed({2'b00, r_best_param});
                w_mb = $signed({1'b0, r_dir_len});
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_shr  = r_prod >>> 16;

    assign w_div_start = (w_accept && !r_active) || ((r_state == S_DIVX) && w_div_done);
    assign w_div_den   = (r_state == S_IDLE) ? r_dx : r_dy;
    assign w_sqrt_start = (r_state == S_SQ) && (r_cnt == 3'd2);

    rbch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    rbch_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_val   (r_sum + r_prod[63:0]),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_root)
    );

    // slab interval
    always_comb begin
        logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
        lo_x = (r_t[0] < r_t[1]) ? r_t[0] : r_t[1];
        hi_x = (r_t[0] > r_t[1]) ? r_t[0] : r_t[1];
        lo_y = (r_t[2] < r_t[3]) ? r_t[2] : r_t[3];
        hi_y = (r_t[2] > r_t[3]) ? r_t[2] : r_t[3];
        w_tmin = (lo_x > lo_y) ? lo_x : lo_y;
        w_tmax = (hi_x < hi_y) ? hi_x : hi_y;
        w_cand = (w_tmax >= w_tmin) && (w_tmax >= 32'sd0) && (w_tmin > 32'sd0)
              && (w_tmin < $signed({1'b0, r_best_param}));
    end

    // overlaps and center offsets at doubled scale
    always_comb begin
        logic signed [35:0] absx, absy;
        w_offx2 = $signed({{3{r_px[31]}}, r_px, 1'b0})
                - ($signed({{4{r_box.box_min_x[31]}}, r_box.box_min_x})
                 + $signed({{4{r_box.box_max_x[31]}}, r_box.box_max_x}));
        w_offy2 = $signed({{3{r_py[31]}}, r_py, 1'b0})
                - ($signed({{4{r_box.box_min_y[31]}}, r_box.box_min_y})
                 + $signed({{4{r_box.box_max_y[31]}}, r_box.box_max_y}));
        absx = w_offx2[35] ? -w_offx2 : w_offx2;
        absy = w_offy2[35] ? -w_offy2 : w_offy2;
        w_ovx2 = ($signed({{4{r_box.box_max_x[31]}}, r_box.box_max_x})
                - $signed({{4{r_box.box_min_x[31]}}, r_box.box_min_x})) - absx;
        w_ovy2 = ($signed({{4{r_box.box_max_y[31]}}, r_box.box_max_y})
                - $signed({{4{r_box.box_min_y[31]}}, r_box.box_min_y})) - absy;
    end

    assign w_dist_full = r_prod[65:16];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = r_active ? S_SLAB : S_DIVX;
                    n_cnt   = '0;
                end
            end
            S_DIVX: begin
                if (w_div_done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (w_div_done) begin
                    n_state = S_SQ;
                    n_cnt   = '0;
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd2) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_SLAB;
                    n_cnt   = '0;
                end
            end
            S_SLAB: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                n_cnt = '0;
                if (w_cand) begin
                    n_state = S_PNT;
                end else begin
                    n_state = r_box.last_box ? S_DIST : S_IDLE;
                end
            end
            S_PNT: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd2) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_cnt   = '0;
                n_state = r_box.last_box ? S_DIST : S_IDLE;
            end
            S_DIST: begin
                if (r_cnt == 3'd0) begin
                    n_cnt = 3'd1;
                end else if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_dx        <= 32'sd65536;
            r_dy        <= '0;
            r_maxp      <= 31'd65536;
            r_active    <= 1'b0;
            r_best_hit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORIGIN_X:  r_ox   <= i_cfg_data;
                    CFG_ORIGIN_Y:  r_oy   <= i_cfg_data;
                    CFG_DIR_X:     r_dx   <= i_cfg_data;
                    CFG_DIR_Y:     r_dy   <= i_cfg_data;
                    CFG_MAX_PARAM: r_maxp <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept && !r_active) begin
                r_active   <= 1'b1;
                r_best_hit <= 1'b0;
            end
            if (r_state == S_NORM) begin
                r_best_hit <= 1'b1;
            end
            if ((r_state == S_DIST) && (r_cnt != 3'd0) && w_slot_free) begin
                r_out_valid <= 1'b1;
                r_active    <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_box <= i_in_data;
            if (!r_active) begin
                r_best_param <= r_maxp;
                r_best_px    <= '0;
                r_best_py    <= '0;
                r_best_nrm   <= NRM_NEG_X;
            end
        end
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        if ((r_state == S_DIVX) && w_div_done) begin
            r_inv_x <= w_div_quot;
        end
        if ((r_state == S_DIVY) && w_div_done) begin
            r_inv_y <= w_div_quot;
        end
        if ((r_state == S_SQ) && (r_cnt == 3'd1)) begin
            r_sum <= r_prod[63:0];
        end
        if ((r_state == S_SQRT) && w_sqrt_done) begin
            r_dir_len <= w_sqrt_root;
        end
        if ((r_state == S_SLAB) && (r_cnt != 3'd0)) begin
            r_t[w_tidx] <= sat32(w_shr);
        end
        if (r_state == S_TEST) begin
            r_tmin <= w_tmin;
        end
        if ((r_state == S_PNT) && (r_cnt == 3'd1)) begin
            r_px <= sat32($signed({{34{r_ox[31]}}, r_ox}) + w_shr);
        end
        if ((r_state == S_PNT) && (r_cnt == 3'd2)) begin
            r_py <= sat32($signed({{34{r_oy[31]}}, r_oy}) + w_shr);
        end
        if (r_state == S_NORM) begin
            r_best_param <= r_tmin[30:0];
            r_best_px    <= r_px;
            r_best_py    <= r_py;
            if (w_ovx2 < w_ovy2) begin
                r_best_nrm <= (w_offx2 > 36'sd0) ? NRM_NEG_X : NRM_POS_X;
            end else begin
                r_best_nrm <= (w_offy2 > 36'sd0) ? NRM_NEG_Y : NRM_POS_Y;
            end
        end
        if ((r_state == S_DIST) && (r_cnt != 3'd0) && w_slot_free) begin
            r_out.hit <= r_best_hit;
            if (r_best_hit) begin
                r_out.distance    <= (w_dist_full > 50'h0_7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                     : w_dist_full[30:0];
                r_out.point_x     <= r_best_px;
                r_out.point_y     <= r_best_py;
                r_out.normal_code <= r_best_nrm;
            end else begin
                r_out.distance    <= '0;
                r_out.point_x     <= '0;
                r_out.point_y     <= '0;
                r_out.normal_code <= NRM_NEG_X;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a result word only appears out of the distance step
    a_out_from_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DIST))
        else $error("result word raised outside distance step");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hit) |->
            (r_out.distance == 31'd0 && r_out.point_x == 32'sd0 && r_out.point_y == 32'sd0))
        else $error("miss result has nonzero fields");

    // an accepted box always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE) && r_active)
        else $error("accepted box did not start work");

    // the kept parameter is always positive and fits the 31-bit field
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_tmin > 32'sd0) && (r_tmin[31] == 1'b0))
        else $error("closest hit parameter out of range");

endmodule
